>>> src/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/bpa_pkg.sv
// package for the bitmap page allocator: sizes, mode codes, control structs
// no dependencies
package bpa_pkg;
  localparam int MaxPages = 65536;
  localparam int WordBits = 64;
  localparam int MapWords = MaxPages / WordBits;
  localparam int PageW = $clog2(MaxPages);
  localparam int CntW = PageW + 1;
  localparam int AddrW = $clog2(MapWords);
  localparam int BitW = $clog2(WordBits);

  localparam logic [1:0] MODE_ALLOC1 = 2'd0;
  localparam logic [1:0] MODE_RUN = 2'd1;
  localparam logic [1:0] MODE_FREE = 2'd2;
  localparam logic [1:0] MODE_RSV = 2'd3;

  typedef struct packed {
    logic load;        // latch request
    logic rd;          // issue read of cur word
    logic scan;        // examine read data
    logic wr;          // write back modified word
  } bpa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;   // search or range walk finished
    logic need_wr;     // current word must be written
  } bpa_sts_t;
endpackage

>>> src/bitmap_page_allocator_core.sv
// bitmap first-fit page allocator core; depends on bpa_pkg, bpa_ctrl, bpa_datapath
// one item at a time: each bitmap word visited goes through read, wait and scan
// states; the result is held until taken, and the next item is only accepted
// after that; the walk covers words searched plus words marked for an alloc,
// words touched for a range, none when no word is needed; at most 2048 words
// rst: clearing pass marks every page used, free count 0, limit 65536
module bitmap_page_allocator_core
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,       // page_limit[16:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode[1:0], base_page[17:2], count[34:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // page_index[15:0], ok[16], free_count[33:17]
);
  bpa_cmd_t cmd;
  bpa_sts_t sts;
  logic [CntW-1:0] total;
  logic [PageW-1:0] res_page;
  logic res_ok;
  logic [CntW-1:0] res_free;

  // config register, saturates at the bitmap capacity
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) total <= CntW'(MaxPages);
    else if (cfg_valid)
      total <= (cfg_data[CntW-1:0] > CntW'(MaxPages)) ? CntW'(MaxPages)
               : cfg_data[CntW-1:0];
  end

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .cmd(cmd), .sts(sts)
  );

  bpa_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_mode(s_axis_tdata[1:0]), .in_start(s_axis_tdata[17:2]),
    .in_count(s_axis_tdata[34:18]), .total(total),
    .res_page(res_page), .res_ok(res_ok), .res_free(res_free)
  );

  assign m_axis_tdata = {6'b0, res_free, res_ok, res_page};
endmodule

>>> src/bpa_ram.sv
// generic single-port ram with registered read
// no dependencies
module bpa_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/bpa_datapath.sv
// datapath: bitmap ram, word walker, run tracker, free counter
// depends on bpa_pkg and bpa_ram
module bpa_datapath
  import bpa_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  bpa_cmd_t        cmd,
  output bpa_sts_t        sts,
  input  logic [1:0]      in_mode,
  input  logic [PageW-1:0] in_start,
  input  logic [CntW-1:0] in_count,
  input  logic [CntW-1:0] total,
  output logic [PageW-1:0] res_page,
  output logic            res_ok,
  output logic [CntW-1:0] res_free
);
  logic [1:0]        mode;
  logic [CntW-1:0]   cnt;
  // walk state
  logic [AddrW:0]    waddr;      // current word, extra bit holds the carry past the last word
  logic [AddrW-1:0]  clr_addr;
  logic              clearing;
  logic              rd_pend;
  logic [CntW-1:0]   run_len;    // length of free run so far
  logic [CntW:0]     run_start;
  logic              phase2;     // range pass: set or clear pages in [lo,hi)
  logic [CntW:0]     lo, hi;     // page range [lo,hi) to set or clear
  logic              done;
  logic [WordBits-1:0] rdata, wword;
  logic [WordBits-1:0] ram_wdata;
  logic              we;
  logic [AddrW-1:0]  ram_addr;
  logic [CntW-1:0]   free_cnt;
  logic [CntW-1:0]   ok_free;

  bpa_ram #(.Width(WordBits), .Depth(MapWords)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rdata)
  );

  assign ram_addr = clearing ? clr_addr : waddr[AddrW-1:0];
  // clearing pass fills every word with ones: all pages used
  assign ram_wdata = clearing ? '1 : wword;
  assign sts.clr_done = !clearing;
  assign sts.scan_done = done;

  // per-word run search: fw[k][e] marks 2^k free pages ending at bit e;
  // the windows for the set bits of cnt are chained into one of cnt pages
  logic [CntW:0]      wbase;
  logic [CntW-1:0]    rl_n;
  logic [CntW:0]      rs_n;
  logic               fnd_n;
  logic [WordBits-1:0] mask;
  logic [CntW-1:0]    delta;
  logic [CntW:0]      p;
  logic [WordBits-1:0] free_bits;   // free and below total
  logic [WordBits-1:0] fw [BitW+1];
  logic [WordBits-1:0] win;         // a run of cnt pages ends at this bit
  logic               win_any;
  logic [BitW:0]      tz, lz;       // free pages at the bottom and top of the word
  logic               tz_hit, lz_hit, first_hit;
  logic [BitW-1:0]    win_end;
  logic               carry_fit;    // run carried in from earlier words completes
  always_comb begin
    wbase = {1'b0, waddr, {BitW{1'b0}}};
    rl_n = run_len;
    rs_n = run_start;
    mask = '0;
    free_bits = '0;
    delta = '0;
    for (int b = 0; b < WordBits; b++) begin
      p = wbase + (CntW+1)'(b);
      if (p >= lo && p < hi) mask[b] = 1'b1;
      if (p < {1'b0, total} && !rdata[b]) free_bits[b] = 1'b1;
    end
    fw[0] = free_bits;
    for (int k = 1; k <= BitW; k++) fw[k] = fw[k-1] & (fw[k-1] << (1 << (k - 1)));
    win = '1;
    win_any = 1'b0;
    for (int k = 0; k <= BitW; k++) begin
      if (cnt[k]) begin
        win = win_any ? (fw[k] & (win << (1 << k))) : fw[k];
        win_any = 1'b1;
      end
    end
    if (!win_any || cnt > CntW'(WordBits)) win = '0;
    tz = (BitW+1)'(WordBits);
    tz_hit = 1'b0;
    for (int b = 0; b < WordBits; b++) begin
      if (!tz_hit && !free_bits[b]) begin
        tz = (BitW+1)'(b);
        tz_hit = 1'b1;
      end
    end
    lz = (BitW+1)'(WordBits);
    lz_hit = 1'b0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (!lz_hit && !free_bits[b]) begin
        lz = (BitW+1)'(WordBits - 1 - b);
        lz_hit = 1'b1;
      end
    end
    win_end = '0;
    first_hit = 1'b0;
    for (int b = 0; b < WordBits; b++) begin
      if (!first_hit && win[b]) begin
        win_end = BitW'(b);
        first_hit = 1'b1;
      end
    end
    carry_fit = ({1'b0, run_len} + (CntW+1)'(tz)) >= {1'b0, cnt};
    fnd_n = carry_fit || first_hit;
    if (carry_fit) begin
      rs_n = run_start;
    end else if (first_hit) begin
      rs_n = wbase + (CntW+1)'(win_end) + 1'b1 - {1'b0, cnt};
    end else if (!tz_hit) begin
      rl_n = run_len + CntW'(WordBits);
    end else begin
      rl_n = CntW'(lz);
      rs_n = wbase + (CntW+1)'(WordBits) - (CntW+1)'(lz);
    end
    if (mode == MODE_FREE) begin
      wword = rdata & ~mask;
      delta = CntW'($countones(rdata & mask));
    end else begin
      wword = rdata | mask;
      delta = CntW'($countones(~rdata & mask));
    end
  end
  assign sts.need_wr = |mask;
  assign we = clearing || (cmd.wr && !rd_pend);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      free_cnt <= '0;
      rd_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AddrW'(MapWords - 1)) clearing <= 1'b0;
      end
      rd_pend <= cmd.rd;
      if (cmd.load) begin
        mode <= in_mode;
        cnt <= (in_mode == MODE_ALLOC1) ? CntW'(1) : in_count;
        waddr <= '0;
        run_len <= '0;
        run_start <= '0;
        phase2 <= 1'b0;
        done <= 1'b0;
        res_ok <= 1'b0;
        res_page <= '0;
        if (in_mode == MODE_FREE || in_mode == MODE_RSV) begin
          lo <= {2'b0, in_start};
          hi <= ({2'b0, in_start} + {1'b0, in_count} < {1'b0, total})
                ? {2'b0, in_start} + {1'b0, in_count} : {1'b0, total};
          waddr <= {1'b0, in_start[PageW-1:BitW]};
          phase2 <= 1'b1;
          if (in_count == '0 || {1'b0, in_start} >= total) done <= 1'b1;
          res_ok <= 1'b1;
        end else begin
          lo <= '0;
          hi <= '0;
          if ((in_mode == MODE_RUN && in_count == '0) || total == '0) done <= 1'b1;
        end
      end else if (cmd.scan) begin
        if (phase2) begin
          if (mode == MODE_FREE) free_cnt <= free_cnt + delta;
          else free_cnt <= free_cnt - delta;
          if (wbase + (CntW+1)'(WordBits) >= hi) done <= 1'b1;
          waddr <= waddr + 1'b1;
        end else begin
          run_len <= rl_n;
          run_start <= rs_n;
          if (fnd_n) begin
            phase2 <= 1'b1;
            lo <= rs_n;
            hi <= rs_n + {1'b0, cnt};
            waddr <= rs_n[CntW-1:BitW];
            res_ok <= 1'b1;
            res_page <= rs_n[PageW-1:0];
            mode <= MODE_RSV;
          end else if (wbase + (CntW+1)'(WordBits) >= {1'b0, total}) begin
            done <= 1'b1;
          end else begin
            waddr <= waddr + 1'b1;
          end
        end
      end
    end
  end
  assign ok_free = free_cnt;
  assign res_free = ok_free;
endmodule

>>> src/bpa_ctrl.sv
// controller state machine: clearing, request load, read/scan/write loop
// depends on bpa_pkg
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  output logic     s_ready,
  output logic     m_valid,
  input  logic     m_ready,
  output bpa_cmd_t cmd,
  input  bpa_sts_t sts
);
  localparam logic [2:0] ST_INIT = 3'd0, ST_IDLE = 3'd1, ST_RD = 3'd2,
    ST_WAIT = 3'd3, ST_SCAN = 3'd4, ST_OUT = 3'd5;
  logic [2:0] state, state_next;

  assign s_ready = (state == ST_IDLE);
  assign m_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_INIT: if (sts.clr_done) state_next = ST_IDLE;
      ST_IDLE: if (s_valid) begin
        cmd.load = 1'b1;
        state_next = ST_RD;
      end
      ST_RD: begin
        if (sts.scan_done) state_next = ST_OUT;
        else begin
          cmd.rd = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: state_next = ST_SCAN;
      ST_SCAN: begin
        cmd.scan = 1'b1;
        cmd.wr = sts.need_wr;
        state_next = ST_RD;
      end
      ST_OUT: if (m_ready) state_next = ST_IDLE;
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end
endmodule

>>> src/bpa_checker.sv
// port-level checker bound to the allocator top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  `ASSERT_IMPL(no_accept_while_out, clk, rst, m_axis_tvalid, !s_axis_tready)
  `ASSERT_NEXT(accept_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ASSERT_IMPL(fail_zero_page, clk, rst, m_axis_tvalid && !m_axis_tdata[16],
               m_axis_tdata[15:0] == 16'd0)
endmodule

bind bitmap_page_allocator_core bpa_checker u_chk (.*);
